>>> src/volume_step_attenuation_ramp_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the volume step attenuation ramp unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOLUME_STEP_ATTENUATION_RAMP_UNIT_MACROS_SVH
`define VOLUME_STEP_ATTENUATION_RAMP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VSAR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define VSAR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VSAR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define VSAR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> src/vsar_pkg.sv
// ----------------------------------------------------------------------------
// vsar_pkg
// Shared widths, codes, reset values and payload types of the volume ramp unit.
// ----------------------------------------------------------------------------
package vsar_pkg;

  localparam int STEP_W     = 8;
  localparam int CODE_W     = 11;
  localparam int REQ_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // divider: quotient never exceeds 1020, dividend 8*num + den fits 20 bits
  localparam int DIV_BITS   = 10;
  localparam int DIVIDEND_W = 20;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS);

  localparam logic [STEP_W-1:0] MIN_VOLUME_STEPS = 8'd10;

  // command codes
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_MUTE   = 2'd1;
  localparam logic [1:0] MODE_UNMUTE = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_STEPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ATTEN_DB = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEN_DB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH  = 3'd6;

  // register reset values
  localparam logic [STEP_W-1:0] RST_VOLUME_STEPS = 8'd64;
  localparam logic [STEP_W-1:0] RST_MIN_ATTEN_DB = 8'd0;
  localparam logic [STEP_W-1:0] RST_MAX_ATTEN_DB = 8'd111;
  localparam logic [STEP_W-1:0] RST_MUTE_LEVEL   = 8'd0;
  localparam logic [STEP_W-1:0] RST_MIN_STEP     = 8'd1;
  localparam logic [STEP_W-1:0] RST_MAX_STEP     = 8'd64;
  localparam logic              RST_PASSTHROUGH  = 1'b0;

  typedef logic signed [CODE_W-1:0] code_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [REQ_W-1:0] requested_step;
    logic                    volume_allowed;
  } in_item_t;

  typedef struct packed {
    code_t level;
    logic  hard_mute;
    logic  ramp_done;
  } out_item_t;

  // mapping settings seen by the code unit
  typedef struct packed {
    logic [STEP_W-1:0] volume_steps;
    logic [STEP_W-1:0] min_atten_db;
    logic [STEP_W-1:0] max_atten_db;
  } atten_cfg_t;

  // code unit status
  typedef struct packed {
    logic  done;
    code_t code;
  } code_rsp_t;

endpackage

>>> src/vsar_code_unit.sv
// ----------------------------------------------------------------------------
// vsar_code_unit
// Step to attenuation code: shared 8x8 multiplier, then restoring divider.
// ----------------------------------------------------------------------------
`include "volume_step_attenuation_ramp_unit_macros.svh"

module vsar_code_unit import vsar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] step,
  input  atten_cfg_t        cfg,
  output code_rsp_t         rsp
);

  localparam logic [1:0] CU_IDLE  = 2'd0;
  localparam logic [1:0] CU_MUL_A = 2'd1;
  localparam logic [1:0] CU_MUL_B = 2'd2;
  localparam logic [1:0] CU_DIV   = 2'd3;

  logic [1:0]            state;
  logic [STEP_W-1:0]     step_q;
  logic [2*STEP_W-1:0]   acc;
  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] dv_sh;
  logic [DIV_BITS-1:0]   quo;
  logic [DIV_CNT_W-1:0]  bit_idx;
  logic                  done_q;
  code_t                 code_q;

  logic [STEP_W-1:0]     range;
  logic [STEP_W-1:0]     den;
  logic                  fallback;
  logic [STEP_W-1:0]     mul_a;
  logic [STEP_W-1:0]     mul_b;
  logic [2*STEP_W-1:0]   prod;
  logic [2*STEP_W-1:0]   num;
  logic                  fits;
  logic [DIV_BITS-1:0]   quo_next;

  assign range = cfg.max_atten_db - cfg.min_atten_db;
  assign den   = cfg.volume_steps - 8'd1;

  assign fallback = (cfg.min_atten_db >= cfg.max_atten_db) || (step == '0) ||
                    (step > cfg.volume_steps) || (cfg.volume_steps < MIN_VOLUME_STEPS) ||
                    (cfg.volume_steps <= (range >> 2));

  // one multiplier, operands picked by the sequencer
  always_comb begin
    if (state == CU_MUL_A) begin
      mul_a = cfg.max_atten_db;
      mul_b = den;
    end else begin
      mul_a = step_q - 8'd1;
      mul_b = range;
    end
  end

  assign prod     = mul_a * mul_b;
  assign num      = acc - prod;
  assign fits     = rem >= dv_sh;
  assign quo_next = {quo[DIV_BITS-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= CU_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state)
        CU_IDLE: begin
          if (start) begin
            step_q <= step;
            if (fallback) begin
              done_q <= 1'b1;
              code_q <= code_t'(-$signed({1'b0, cfg.min_atten_db, 2'b00}));
            end else begin
              state <= CU_MUL_A;
            end
          end
        end
        CU_MUL_A: begin
          acc   <= prod;
          state <= CU_MUL_B;
        end
        CU_MUL_B: begin
          // dividend 2*(4*num) + den, divisor 2*den
          rem     <= {1'b0, num, 3'b000} + DIVIDEND_W'(den);
          dv_sh   <= DIVIDEND_W'({den, 1'b0}) << (DIV_BITS - 1);
          quo     <= '0;
          bit_idx <= DIV_CNT_W'(DIV_BITS - 1);
          state   <= CU_DIV;
        end
        CU_DIV: begin
          if (fits) begin
            rem <= rem - dv_sh;
          end
          dv_sh   <= dv_sh >> 1;
          quo     <= quo_next;
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == '0) begin
            done_q <= 1'b1;
            code_q <= code_t'(-$signed({1'b0, quo_next}));
            state  <= CU_IDLE;
          end
        end
        default: state <= CU_IDLE;
      endcase
    end
  end

  assign rsp.done = done_q;
  assign rsp.code = code_q;

  `VSAR_ASSERT_IMPLY(a_start_idle, clk, rst, start, state == CU_IDLE,
                     "code unit started while busy")
  `VSAR_ASSERT_IMPLY(a_code_nonpos, clk, rst, done_q,
                     code_q[CODE_W-1] || (code_q == '0), "positive code")
  `VSAR_ASSERT_NEXT(a_div_bound, clk, rst, state == CU_MUL_B,
                    rem < (dv_sh << 1), "quotient overflow")

endmodule

>>> src/volume_step_attenuation_ramp_unit.sv
// ----------------------------------------------------------------------------
// volume_step_attenuation_ramp_unit
// Volume command processor with quarter-dB attenuation ramp.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer (set volume, mute, unmute, tick).
//   out_* : zero or one chip write per command (level, hard_mute, ramp_done).
//   cfg_* : register writes, one per cycle with cfg_write high; only while idle.
// Sequencing:
//   set volume and unmute compute two codes, one after the other, on the shared
//   code unit before their write is placed. Mute with a level needs one code;
//   hard mute and tick need none. Out-of-range settings take the fallback code
//   straight from the code unit's idle state, with no multiply or divide.
//   The code unit sets the pace: one multiplier used twice, then a 10-step
//   restoring divider. One command is in flight at a time; in_stall is high
//   from acceptance until its write has been placed in the output register.
// Reset: rst clears volume state and loads the register defaults.
// Stall: a write waits in the output register while out_stall is high; the
//   next command may already be accepted and holds until the slot is free.
// ----------------------------------------------------------------------------
`include "volume_step_attenuation_ramp_unit_macros.svh"

module volume_step_attenuation_ramp_unit import vsar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // chip write channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // register port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // ready for a command
  localparam logic [2:0] S_FROM = 3'd1;  // code of the old step
  localparam logic [2:0] S_TO   = 3'd2;  // code of the new step
  localparam logic [2:0] S_MUTE = 3'd3;  // code of mute_level
  localparam logic [2:0] S_OUT  = 3'd4;  // waiting for the output slot

  // configuration
  logic [STEP_W-1:0] volume_steps;
  logic [STEP_W-1:0] min_atten_db;
  logic [STEP_W-1:0] max_atten_db;
  logic [STEP_W-1:0] mute_level;
  logic [STEP_W-1:0] min_step;
  logic [STEP_W-1:0] max_step;
  logic              passthrough;

  // volume state
  logic [2:0]        state;
  logic [STEP_W-1:0] current_step;
  logic              muted_flag;
  code_t             ramp_position;
  code_t             ramp_target;
  logic              ramp_active;

  // per-command payload
  logic [STEP_W-1:0] new_step;
  code_t             from_code;
  out_item_t         pending;

  logic                    in_accept;
  logic                    out_load;
  logic signed [REQ_W-1:0] req_sel;
  logic signed [REQ_W-1:0] min_s;
  logic signed [REQ_W-1:0] max_s;
  logic signed [REQ_W-1:0] req_clamped;
  logic [STEP_W-1:0]       new_step_sel;
  code_t                   pos_next;
  logic                    active_next;

  logic              cu_start;
  logic [STEP_W-1:0] cu_step;
  atten_cfg_t        cu_cfg;
  code_rsp_t         cu_rsp;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_steps <= RST_VOLUME_STEPS;
      min_atten_db <= RST_MIN_ATTEN_DB;
      max_atten_db <= RST_MAX_ATTEN_DB;
      mute_level   <= RST_MUTE_LEVEL;
      min_step     <= RST_MIN_STEP;
      max_step     <= RST_MAX_STEP;
      passthrough  <= RST_PASSTHROUGH;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VOLUME_STEPS: volume_steps <= cfg_data;
        REG_MIN_ATTEN_DB: min_atten_db <= cfg_data;
        REG_MAX_ATTEN_DB: max_atten_db <= cfg_data;
        REG_MUTE_LEVEL:   mute_level   <= cfg_data;
        REG_MIN_STEP:     min_step     <= cfg_data;
        REG_MAX_STEP:     max_step     <= cfg_data;
        REG_PASSTHROUGH:  passthrough  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Step clamp: unmute re-applies the stored step. min_step is tested first,
  // so with min above max a request below min_step gets min_step, any other max_step.
  assign req_sel = (in_data.mode == MODE_UNMUTE) ? $signed({8'd0, current_step})
                                                 : in_data.requested_step;
  assign min_s   = $signed({8'd0, min_step});
  assign max_s   = $signed({8'd0, max_step});

  always_comb begin
    if (req_sel < min_s) begin
      req_clamped = min_s;
    end else if (req_sel > max_s) begin
      req_clamped = max_s;
    end else begin
      req_clamped = req_sel;
    end
  end

  assign new_step_sel = passthrough ? max_step : req_clamped[STEP_W-1:0];

  // ramp moves one code toward the target per tick
  always_comb begin
    if (ramp_position < ramp_target) begin
      pos_next = ramp_position + 11'sd1;
    end else if (ramp_position > ramp_target) begin
      pos_next = ramp_position - 11'sd1;
    end else begin
      pos_next = ramp_position;
    end
  end

  assign active_next = (pos_next != ramp_target);

  // code unit launch
  always_comb begin
    cu_start = 1'b0;
    cu_step  = current_step;
    if (state == S_IDLE && in_accept) begin
      case (in_data.mode)
        MODE_SET:    cu_start = in_data.volume_allowed && !muted_flag;
        MODE_UNMUTE: cu_start = in_data.volume_allowed;
        MODE_MUTE: begin
          cu_start = (mute_level != '0);
          cu_step  = mute_level;
        end
        default: cu_start = 1'b0;
      endcase
    end else if (state == S_FROM && cu_rsp.done) begin
      cu_start = 1'b1;
      cu_step  = new_step;
    end
  end

  assign cu_cfg.volume_steps = volume_steps;
  assign cu_cfg.min_atten_db = min_atten_db;
  assign cu_cfg.max_atten_db = max_atten_db;

  vsar_code_unit u_code (
    .clk   (clk),
    .rst   (rst),
    .start (cu_start),
    .step  (cu_step),
    .cfg   (cu_cfg),
    .rsp   (cu_rsp)
  );

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      current_step  <= '0;
      muted_flag    <= 1'b0;
      ramp_position <= '0;
      ramp_target   <= '0;
      ramp_active   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_data.mode)
              MODE_SET: begin
                // muted: clamp only, nothing stored or written
                if (in_data.volume_allowed && !muted_flag) begin
                  new_step <= new_step_sel;
                  state    <= S_FROM;
                end
              end
              MODE_UNMUTE: begin
                muted_flag <= 1'b0;
                if (in_data.volume_allowed) begin
                  new_step <= new_step_sel;
                  state    <= S_FROM;
                end
              end
              MODE_MUTE: begin
                ramp_active <= 1'b0;
                muted_flag  <= 1'b1;
                if (mute_level != '0) begin
                  state <= S_MUTE;
                end else begin
                  pending <= '{level: '0, hard_mute: 1'b1, ramp_done: 1'b1};
                  state   <= S_OUT;
                end
              end
              default: begin
                // tick with no ramp gives no write
                if (ramp_active) begin
                  ramp_position <= pos_next;
                  ramp_active   <= active_next;
                  pending <= '{level: pos_next, hard_mute: 1'b0, ramp_done: !active_next};
                  state   <= S_OUT;
                end
              end
            endcase
          end
        end
        S_FROM: begin
          if (cu_rsp.done) begin
            from_code    <= cu_rsp.code;
            current_step <= new_step;
            state        <= S_TO;
          end
        end
        S_TO: begin
          if (cu_rsp.done) begin
            // any older ramp is replaced; equal codes finish at once
            ramp_position <= from_code;
            ramp_target   <= cu_rsp.code;
            ramp_active   <= (from_code != cu_rsp.code);
            pending <= '{level: from_code, hard_mute: 1'b0,
                         ramp_done: (from_code == cu_rsp.code)};
            state   <= S_OUT;
          end
        end
        S_MUTE: begin
          if (cu_rsp.done) begin
            pending <= '{level: cu_rsp.code, hard_mute: 1'b0, ramp_done: 1'b1};
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= pending;
    end
  end

  `VSAR_ASSERT_IMPLY(a_ramp_open, clk, rst, ramp_active,
                     ramp_position != ramp_target, "ramp active at target")
  `VSAR_ASSERT_NEXT(a_out_load, clk, rst, out_load,
                    out_valid && (state == S_IDLE), "write not placed")
  `VSAR_ASSERT_NEXT(a_muted_set, clk, rst,
                    in_accept && (in_data.mode == MODE_SET) && muted_flag,
                    state == S_IDLE, "set while muted not dropped")
  `VSAR_ASSERT_NEXT(a_idle_tick, clk, rst,
                    in_accept && (in_data.mode == MODE_TICK) && !ramp_active,
                    (state == S_IDLE) && !ramp_active, "idle tick changed state")

endmodule
